### hdl/chse_pkg.sv
// ----------------------------------------------------------------------------
// chse_pkg: shared types and constants for the cipher suite extractor
// Record and hello offsets, status codes and the job handed from the byte
// parser to the result emitter.
// ----------------------------------------------------------------------------
package chse_pkg;

   // content type of a TLS handshake record
   localparam logic [7:0]  HS_RECORD  = 8'h16;
   // offset of the session ID length byte
   localparam logic [15:0] SID_OFFSET = 16'd43;
   // list start = SID_OFFSET + 3 + session ID length
   localparam logic [15:0] LIST_BIAS  = 16'd46;
   // minimum lengths, compared against a 17-bit payload length
   localparam logic [16:0] MIN_RECORD = 17'd5;
   localparam logic [16:0] MIN_HELLO  = 17'd9;
   localparam logic [16:0] MIN_SID    = 17'd44;
   // saturation point of the byte position
   localparam logic [15:0] POS_MAX    = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOT_HS = 2'd1,
      ST_SHORT  = 2'd2
   } status_type;

   // one finished payload, waiting for its results to go out
   typedef struct packed {
      status_type  status;
      logic [15:0] version;
      logic        has_suites;
   } job_type;

endpackage

### hdl/chse_parser.sv
// ----------------------------------------------------------------------------
// chse_parser: per-byte ClientHello parser
// Tracks the byte position, captures record type, version, list start and
// list length, writes kept suites to the suite store and builds the job
// (status, version, count) on the last byte of a payload.
// ----------------------------------------------------------------------------
module chse_parser #(
   parameter int MAX_SUITES = 16,
   localparam int IW = (MAX_SUITES > 1) ? $clog2(MAX_SUITES) : 1,
   localparam int CW = $clog2(MAX_SUITES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [7:0]        byte_data,
   input  logic              byte_first,
   input  logic              byte_last,
   output logic              wr_en,
   output logic [IW-1:0]     wr_addr,
   output logic [15:0]       wr_data,
   output logic              job_load,
   output chse_pkg::job_type job_data,
   output logic [CW-1:0]     job_count
);

   localparam logic [15:0] LIST_SPAN = 16'(2 * MAX_SUITES);
   localparam logic [14:0] CNT_CAP   = 15'(MAX_SUITES);

   logic [15:0] pos_ff, pos_in;
   logic [7:0]  first_ff, first_in;
   logic [15:0] ver_ff, ver_in;
   logic [15:0] ls_ff, ls_in;
   logic [15:0] ll_ff, ll_in;
   logic [7:0]  hold_ff, hold_in;

   logic [15:0] idx;
   logic [15:0] off;
   logic        in_list;
   logic [16:0] len;
   logic [16:0] list_end;
   logic [14:0] half_len;
   chse_pkg::status_type st;

   // field capture at the current byte position
   always_comb begin
      idx      = byte_first ? 16'd0 : pos_ff;
      first_in = byte_first ? 8'd0  : first_ff;
      ver_in   = byte_first ? 16'd0 : ver_ff;
      ls_in    = byte_first ? 16'd0 : ls_ff;
      ll_in    = byte_first ? 16'd0 : ll_ff;
      hold_in  = byte_first ? 8'd0  : hold_ff;
      off      = idx - ls_in;
      in_list  = (idx >= ls_in) && (off < LIST_SPAN);
      wr_en    = 1'b0;
      wr_addr  = off[IW:1];
      wr_data  = {hold_in, byte_data};

      if (idx == 16'd0) begin
         first_in = byte_data;
      end else if (idx == 16'd1) begin
         ver_in = {byte_data, 8'd0};
      end else if (idx == 16'd2) begin
         ver_in = {ver_in[15:8], byte_data};
      end else if (idx == chse_pkg::SID_OFFSET) begin
         ls_in = chse_pkg::LIST_BIAS + {8'd0, byte_data};
      end else if (idx > chse_pkg::SID_OFFSET) begin
         if (idx == ls_in - 16'd2) begin
            hold_in = byte_data;
         end else if (idx == ls_in - 16'd1) begin
            ll_in = {hold_in, byte_data};
         end else if (in_list) begin
            if (!off[0]) begin
               hold_in = byte_data;
            end else begin
               wr_en = byte_valid;
            end
         end
      end

      pos_in = (idx < chse_pkg::POS_MAX) ? idx + 16'd1 : idx;
   end

   // status and count at the last byte
   always_comb begin
      len      = {1'b0, idx} + 17'd1;
      list_end = {1'b0, ls_in} + {1'b0, ll_in};
      half_len = ll_in[15:1];

      if (len < chse_pkg::MIN_RECORD) begin
         st = chse_pkg::ST_SHORT;
      end else if (first_in != chse_pkg::HS_RECORD) begin
         st = chse_pkg::ST_NOT_HS;
      end else if (len < chse_pkg::MIN_HELLO || len < chse_pkg::MIN_SID ||
                   len < {1'b0, ls_in} || len < list_end) begin
         st = chse_pkg::ST_SHORT;
      end else begin
         st = chse_pkg::ST_OK;
      end

      job_load = byte_valid && byte_last;
      job_data.status = st;
      if (st == chse_pkg::ST_OK) begin
         job_data.version = ver_in;
         job_count = (half_len > CNT_CAP) ? CW'(MAX_SUITES) : CW'(half_len);
      end else begin
         job_data.version = 16'd0;
         job_count = '0;
      end
      job_data.has_suites = (job_count != '0);
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         first_ff <= '0;
         ver_ff   <= '0;
         ls_ff    <= '0;
         ll_ff    <= '0;
         hold_ff  <= '0;
      end else if (byte_valid) begin
         pos_ff   <= pos_in;
         first_ff <= first_in;
         ver_ff   <= ver_in;
         ls_ff    <= ls_in;
         ll_ff    <= ll_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

### hdl/chse_emitter.sv
// ----------------------------------------------------------------------------
// chse_emitter: suite store and result sequencer
// Holds one finished job, walks its kept suites out of the suite store one per
// cycle unless out_ready stalls, and drives the registered result channel.
// ----------------------------------------------------------------------------
module chse_emitter #(
   parameter int MAX_SUITES = 16,
   localparam int IW = (MAX_SUITES > 1) ? $clog2(MAX_SUITES) : 1,
   localparam int CW = $clog2(MAX_SUITES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [IW-1:0]     wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              job_load,
   input  chse_pkg::job_type job_data,
   input  logic [CW-1:0]     job_count,
   output logic              job_free,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [47:0]       out_data,
   output logic              out_last
);

   localparam int SW = CW + 1;

   logic [15:0] store [MAX_SUITES];
   logic [15:0] rd_data_ff;
   logic [IW-1:0] rd_addr;

   logic              active_ff, active_in;
   chse_pkg::job_type job_ff;
   logic [CW-1:0]     cnt_ff;
   logic [IW-1:0]     k_ff, k_in;

   logic        valid_ff, valid_in;
   logic [1:0]  st_ff;
   logic [15:0] ver_ff;
   logic [4:0]  cnt_out_ff;
   logic [3:0]  idx_ff;
   logic [15:0] suite_ff;
   logic        last_ff;

   logic        out_free;
   logic        advance;
   logic        final_res;
   logic [IW+3:0] k_ext;
   logic [CW+4:0] cnt_ext;

   // sequencing of the kept suites
   always_comb begin
      out_free  = !valid_ff || out_ready;
      advance   = active_ff && out_free;
      final_res = advance && (!job_ff.has_suites ||
                  (SW'(k_ff) + SW'(1) == SW'(cnt_ff)));
      job_free  = !active_ff || final_res;

      if (job_load) begin
         active_in = 1'b1;
         k_in      = '0;
      end else begin
         active_in = final_res ? 1'b0 : active_ff;
         k_in      = advance ? k_ff + IW'(1) : k_ff;
      end
      rd_addr  = k_in;
      valid_in = advance ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      k_ext    = (IW + 4)'(k_ff);
      cnt_ext  = (CW + 5)'(cnt_ff);
   end

   // suite store, read data registered with same-cycle write forwarding
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (wr_en && wr_addr == rd_addr) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // job slot
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      k_ff <= k_in;
      if (job_load) begin
         job_ff <= job_data;
         cnt_ff <= job_count;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         st_ff      <= job_ff.status;
         ver_ff     <= job_ff.version;
         cnt_out_ff <= cnt_ext[4:0];
         idx_ff     <= job_ff.has_suites ? k_ext[3:0] : 4'd0;
         suite_ff   <= job_ff.has_suites ? rd_data_ff : 16'd0;
         last_ff    <= final_res;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = {5'd0, suite_ff, idx_ff, cnt_out_ff, ver_ff, st_ff};
   assign out_last  = last_ff;

endmodule

### hdl/tls_client_hello_suite_extract.sv
// ----------------------------------------------------------------------------
// tls_client_hello_suite_extract: TLS ClientHello cipher suite extractor
// Byte-wide payload in, one result per kept cipher suite out.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one TCP payload byte per transfer; tuser marks the first
//   byte of a payload (parsing restarts), tlast marks its final byte.
//   rsp channel: results of a payload go out after its last byte: a single
//   result with the status on a failed parse or an empty suite list, else
//   one result per kept suite (up to MAX_SUITES), tlast on the final one.
//   The first result follows the last byte taken through the job slot and
//   then the result register. Throughput: one byte per cycle; after the
//   last byte of a payload the request side waits while that payload's
//   results are walked out of the suite store, one result per cycle while
//   rsp_tready does not stall them, the suite store's single read port
//   setting the result rate.
//   A stalled rsp_tready holds the result register and, once the pending
//   payload's results are all queued, only that register: bytes of the next
//   payload are taken in the meantime until its own last byte.
//   Reset clears the parse state and drops any pending results; the suite
//   store needs no clearing.
// ----------------------------------------------------------------------------
module tls_client_hello_suite_extract #(
   parameter int MAX_SUITES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   input  logic        req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [1:0] status, [17:2] record_version,
                                    // [22:18] suite_count, [26:23] suite_index,
                                    // [42:27] cipher_suite, [47:43] zero
   output logic        rsp_tlast    // last_result
);

   localparam int IW = (MAX_SUITES > 1) ? $clog2(MAX_SUITES) : 1;
   localparam int CW = $clog2(MAX_SUITES + 1);

   logic              byte_valid;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [15:0]       wr_data;
   logic              job_load;
   chse_pkg::job_type job_data;
   logic [CW-1:0]     job_count;
   logic              job_free;

   // a byte is taken whenever the job slot is free this cycle
   assign req_tready = job_free;
   assign byte_valid = req_tvalid && job_free;

   chse_parser #(
      .MAX_SUITES(MAX_SUITES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (req_tdata),
      .byte_first (req_tuser),
      .byte_last  (req_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .job_load   (job_load),
      .job_data   (job_data),
      .job_count  (job_count)
   );

   chse_emitter #(
      .MAX_SUITES(MAX_SUITES)
   ) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .job_load   (job_load),
      .job_data   (job_data),
      .job_count  (job_count),
      .job_free   (job_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

### tb/sv/tls_client_hello_suite_extract_tb.sv
// ----------------------------------------------------------------------------
// tls_client_hello_suite_extract_tb: self-checking bench for the suite extractor
// Streams TCP payloads (directed corner cases, then random ClientHellos,
// truncated and broken payloads) into the block with random gaps and
// back-pressure. A scoreboard class tracks the parse state per byte and
// compares every result transfer against the predicted queue.
// ----------------------------------------------------------------------------
module tls_client_hello_suite_extract_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUITE_CAP = 16;

   // one expected result transfer
   typedef struct {
      chse_pkg::status_type status;
      logic [15:0]          version;
      logic [4:0]           count;
      logic [3:0]           index;
      logic [15:0]          suite;
      logic                 last;
   } suite_result_type;

   // ------------------------------------------------------------------------
   // Scoreboard: per-byte parse tracking and result comparison
   // ------------------------------------------------------------------------
   class suite_scoreboard;
      logic [15:0]      pos;
      logic [7:0]       lead;
      logic [15:0]      ver;
      int unsigned      list_begin;
      logic [15:0]      list_len;
      logic [7:0]       hold;
      logic [15:0]      store [SUITE_CAP];
      suite_result_type awaited[$];
      int               errors;

      function new();
         clear_parse();
         foreach (store[k]) store[k] = '0;
         errors = 0;
      endfunction

      function void clear_parse();
         pos        = '0;
         lead       = '0;
         ver        = '0;
         list_begin = 0;
         list_len   = '0;
         hold       = '0;
      endfunction

      function void queue_result(chse_pkg::status_type st, logic [15:0] v,
                                 int cnt, int idx, logic [15:0] suite, logic last);
         suite_result_type r;
         r.status  = st;
         r.version = v;
         r.count   = 5'(cnt);
         r.index   = 4'(idx);
         r.suite   = suite;
         r.last    = last;
         awaited.push_back(r);
      endfunction

      // update parse state with one accepted byte; queue results on the last one
      function void note_byte(logic [7:0] b, logic first, logic last);
         int unsigned          i;
         int unsigned          off;
         int unsigned          plen;
         int                   cnt;
         chse_pkg::status_type st;
         if (first) clear_parse();
         i = pos;
         if (i == 0) begin
            lead = b;
         end else if (i == 1) begin
            ver = {b, 8'h00};
         end else if (i == 2) begin
            ver = ver | {8'h00, b};
         end else if (i == chse_pkg::SID_OFFSET) begin
            list_begin = chse_pkg::LIST_BIAS + b;
         end else if (i > chse_pkg::SID_OFFSET) begin
            if (i == list_begin - 2) begin
               hold = b;
            end else if (i == list_begin - 1) begin
               list_len = {hold, b};
            end else if (i >= list_begin && i - list_begin < 2 * SUITE_CAP) begin
               off = i - list_begin;
               if (!off[0]) hold = b;
               else store[(off >> 1) % SUITE_CAP] = {hold, b};
            end
         end
         if (pos != chse_pkg::POS_MAX) pos++;
         if (!last) return;

         // status in priority order
         plen = i + 1;
         if (plen < chse_pkg::MIN_RECORD) st = chse_pkg::ST_SHORT;
         else if (lead != chse_pkg::HS_RECORD) st = chse_pkg::ST_NOT_HS;
         else if (plen < chse_pkg::MIN_HELLO || plen < chse_pkg::MIN_SID
                  || plen < list_begin || plen < list_begin + list_len)
            st = chse_pkg::ST_SHORT;
         else st = chse_pkg::ST_OK;

         if (st != chse_pkg::ST_OK) begin
            queue_result(st, '0, 0, 0, '0, 1'b1);
         end else begin
            cnt = list_len / 2;
            if (cnt > SUITE_CAP) cnt = SUITE_CAP;
            if (cnt == 0) queue_result(chse_pkg::ST_OK, ver, 0, 0, '0, 1'b1);
            for (int k = 0; k < cnt; k++)
               queue_result(chse_pkg::ST_OK, ver, cnt, k, store[k], k == cnt - 1);
         end
      endfunction

      task report(string what);
         errors++;
         $display("ERROR @%0t: %s", $time, what);
      endtask

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
      endtask

      // compare one result transfer against the oldest prediction
      task check_result(logic [47:0] d, logic l);
         suite_result_type e;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result %h last %b", d, l));
            return;
         end
         e = awaited.pop_front();
         check_field("status", 16'(d[1:0]), 16'(e.status));
         check_field("record_version", d[17:2], e.version);
         check_field("suite_count", 16'(d[22:18]), 16'(e.count));
         check_field("suite_index", 16'(d[26:23]), 16'(e.index));
         check_field("cipher_suite", d[42:27], e.suite);
         check_field("pad", 16'(d[47:43]), 16'h0000);
         check_field("last_result", 16'(l), 16'(e.last));
      endtask

      function int pending();
         return awaited.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Signals and DUT
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] payload_byte
   logic        req_tuser  = 1'b0; // [0] first_byte
   logic        req_tlast  = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [1:0] status, [17:2] record_version,
                                  // [22:18] suite_count, [26:23] suite_index,
                                  // [42:27] cipher_suite, [47:43] zero
   logic        rsp_tlast;        // last_result

   suite_scoreboard board = new();

   logic [7:0] frame[$];
   bit         steady     = 1'b0; // no sender gaps
   bit         calm       = 1'b0; // no gaps on either side
   bit         stall_sink = 1'b0; // request a long receiver hold-off
   int         bytes_sent = 0;

   tls_client_hello_suite_extract #(.MAX_SUITES(SUITE_CAP)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_byte(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // ------------------------------------------------------------------------
   // Payload builders and driver
   // ------------------------------------------------------------------------
   task automatic push_random(int n);
      repeat (n) frame.push_back(8'($urandom_range(0, 255)));
   endtask

   // record header, hello body up to the session ID, session ID, list, tail
   task automatic build_hello(logic [7:0] rtype, int sid, int llen, int tail);
      frame.delete();
      frame.push_back(rtype);
      push_random(2 + 40);
      frame.push_back(8'(sid));
      push_random(sid);
      frame.push_back(8'(llen >> 8));
      frame.push_back(8'(llen));
      push_random(llen);
      push_random(tail);
   endtask

   task automatic truncate_frame(int n);
      while (frame.size() > n) void'(frame.pop_back());
   endtask

   // send frame[lo..hi]; first mark on lo, last mark on hi
   task automatic send_frame(int lo, int hi, bit mark_first, bit mark_last);
      for (int i = lo; i <= hi; i++) begin
         req_tvalid <= 1'b1;
         req_tdata  <= frame[i];
         req_tuser  <= mark_first && (i == lo);
         req_tlast  <= mark_last && (i == hi);
         do @(posedge clock); while (!req_tready);
         bytes_sent++;
         if (!steady && !calm && $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   endtask

   task automatic send_whole();
      send_frame(0, frame.size() - 1, 1'b1, 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random ready bursts, one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : sink
      @(posedge clock);
      forever begin
         if (stall_sink) begin
            stall_sink = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int kind;
      int sid;
      int llen;
      int cut;
      logic [7:0] rtype;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single byte payload: too short
      frame.delete(); frame.push_back(chse_pkg::HS_RECORD);
      send_whole();
      // four bytes: still below a record header
      frame.delete(); frame.push_back(8'h00); push_random(3);
      send_whole();
      // five bytes, wrong content type
      frame.delete(); frame.push_back(8'h00); push_random(4);
      send_whole();
      // five and nine bytes of a handshake record: no hello body
      frame.delete(); frame.push_back(chse_pkg::HS_RECORD); push_random(4);
      send_whole();
      frame.delete(); frame.push_back(chse_pkg::HS_RECORD); push_random(8);
      send_whole();
      // ends right at / after the session ID length: no room for list length
      build_hello(chse_pkg::HS_RECORD, 0, 4, 0); truncate_frame(44);
      send_whole();
      build_hello(chse_pkg::HS_RECORD, 0, 4, 0); truncate_frame(45);
      send_whole();
      // empty suite list
      build_hello(chse_pkg::HS_RECORD, 0, 0, 0);
      send_whole();
      // list runs one byte past the end
      build_hello(chse_pkg::HS_RECORD, 3, 8, 0); truncate_frame(frame.size() - 1);
      send_whole();
      // extreme version and suite values
      build_hello(chse_pkg::HS_RECORD, 0, 4, 0);
      frame[1] = 8'hFF; frame[2] = 8'hFF;
      frame[46] = 8'hFF; frame[47] = 8'hFF; frame[48] = 8'h00; frame[49] = 8'h00;
      send_whole();
      build_hello(chse_pkg::HS_RECORD, 1, 2, 2);
      frame[1] = 8'h00; frame[2] = 8'h00;
      send_whole();
      // count capped at the store size, odd list lengths
      build_hello(chse_pkg::HS_RECORD, 32, 40, 0);
      send_whole();
      build_hello(chse_pkg::HS_RECORD, 0, 33, 1);
      send_whole();
      build_hello(chse_pkg::HS_RECORD, 2, 5, 0);
      send_whole();
      build_hello(chse_pkg::HS_RECORD, 0, 1, 0);
      send_whole();
      // largest session ID
      build_hello(chse_pkg::HS_RECORD, 255, 4, 10);
      send_whole();
      // short payload with a non-handshake first byte still reports short
      frame.delete(); frame.push_back(8'h17); push_random(2);
      send_whole();
      build_hello(8'hFF, 0, 4, 0);
      send_whole();
      // last mark mid-hello, then the rest without a first mark
      build_hello(chse_pkg::HS_RECORD, 1, 6, 0);
      send_frame(0, 20, 1'b1, 1'b1);
      send_frame(21, frame.size() - 1, 1'b0, 1'b1);
      // a new first mark restarts an unfinished payload
      frame.delete(); push_random(30);
      send_frame(0, 29, 1'b1, 1'b0);
      build_hello(chse_pkg::HS_RECORD, 0, 6, 0);
      send_whole();

      // payloads past the position saturation point
      steady = 1'b1;
      build_hello(chse_pkg::HS_RECORD, 0, 65480, 34);
      send_whole();
      build_hello(chse_pkg::HS_RECORD, 0, 65535, 20);
      send_whole();
      steady = 1'b0;

      // long receiver hold-off while full hellos keep coming
      stall_sink = 1'b1;
      repeat (3) begin
         build_hello(chse_pkg::HS_RECORD, $urandom_range(0, 4), 32, 0);
         send_whole();
      end

      // random part
      bytes_sent = 0;
      while (bytes_sent < 410) begin
         if (bytes_sent >= 340) calm = 1'b1;
         kind = $urandom_range(0, 9);
         sid  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
         case ($urandom_range(0, 9))
            0:       llen = 0;
            1:       llen = 2 * $urandom_range(0, 4) + 1;
            2:       llen = $urandom_range(33, 40);
            default: llen = 2 * $urandom_range(1, 8);
         endcase
         build_hello(chse_pkg::HS_RECORD, sid, llen, $urandom_range(0, 3));
         if (kind <= 5) begin
            send_whole();
         end else if (kind == 6) begin
            truncate_frame($urandom_range(1, frame.size() - 1));
            send_whole();
         end else if (kind == 7) begin
            rtype = 8'($urandom_range(0, 255));
            if (rtype == chse_pkg::HS_RECORD) rtype = ~rtype;
            frame[0] = rtype;
            send_whole();
         end else if (kind == 8) begin
            frame.delete(); push_random($urandom_range(1, 12));
            send_frame(0, frame.size() - 1, $urandom_range(0, 5) != 0, 1'b1);
         end else begin
            cut = $urandom_range(1, frame.size() - 2);
            send_frame(0, cut, 1'b1, 1'b1);
            send_frame(cut + 1, frame.size() - 1, 1'b0, 1'b1);
         end
      end
      req_tvalid <= 1'b0;

      // drain, then wait on for stray results
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
